// ----- hw/rtl/bvfd_pkg.sv -----
package bvfd_pkg;

    localparam int MAX_SLOTS    = 4;
    localparam int DEF_SLOTS    = 4;
    localparam int CSTEPS       = 16;
    localparam int ANG_W        = 17;
    localparam int MAG_W        = 16;
    localparam int SPD_W        = 10;
    localparam int OUT_W        = 16;
    // internal angle width, 2^23 = pi
    localparam int ZW           = 25;
    // rotator datapath width (mag*39797 < 2^32, cordic growth < 2 bits)
    localparam int RW           = 36;
    // vectoring datapath width (sum of four rotations plus growth)
    localparam int VW           = 40;
    localparam int SPD_RESET    = 500;
    localparam logic [15:0] INV_GAIN = 16'd39797;
    localparam logic [ZW-1:0] HALF_TURN    = ZW'(8388608);
    localparam logic [ZW-1:0] QUARTER_TURN = ZW'(4194304);

    function automatic logic [ZW-1:0] atan_lut(input logic [3:0] i);
        logic [ZW-1:0] v;
        v = '0;
        case (i)
            4'd0:  v = ZW'(2097152);
            4'd1:  v = ZW'(1238021);
            4'd2:  v = ZW'(654136);
            4'd3:  v = ZW'(332050);
            4'd4:  v = ZW'(166669);
            4'd5:  v = ZW'(83416);
            4'd6:  v = ZW'(41718);
            4'd7:  v = ZW'(20860);
            4'd8:  v = ZW'(10430);
            4'd9:  v = ZW'(5215);
            4'd10: v = ZW'(2608);
            4'd11: v = ZW'(1304);
            4'd12: v = ZW'(652);
            4'd13: v = ZW'(326);
            4'd14: v = ZW'(163);
            default: v = ZW'(81);
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/behavior_vector_fusion_drive.sv -----
// channel   | dir | tdata fields (low bit up)                       | tuser
// s_axis    | in  | per slot k: angle 17, magnitude 16, active 1     | -
// m_axis    | out | left_speed 16, right_speed 16, heading 17        | -
// cfg       | in  | base_speed 10 (write enable, no read-back)
// one word per cycle when not stalled; stages in order: 16 rotator cells, sum, 16 vectoring
// cells, heading, 16 rotator cells for cos(h/2), speed multiply, output
// the whole pipe advances together; it stalls only when the output stage is
// full and not taken
// reset is synchronous active low, clears valid bits and base_speed to 500
module behavior_vector_fusion_drive import bvfd_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // per slot from bit 34*k: angle[16:0], magnitude[32:17], active[33]
    input  logic [((34*SLOTS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // left_speed[15:0], right_speed[31:16], heading[48:32]
    output logic [55:0]                     m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [SPD_W-1:0]                i_cfg_wdata
);
    localparam int LAT = 3*CSTEPS + 4;

    logic [SPD_W-1:0] r_spd;
    logic [LAT-1:0]   r_vld;
    logic             w_en;

    // pipe moves unless the last stage holds an untaken word
    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd <= SPD_W'(SPD_RESET);
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_spd <= i_cfg_wdata;
            if (w_en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // per-slot rotators
    logic signed [RW-1:0] w_vx [SLOTS];
    logic signed [RW-1:0] w_vy [SLOTS];
    logic [SLOTS-1:0]     r_act [CSTEPS];

    for (genvar k = 0; k < SLOTS; k++) begin : g_slot
        bvfd_rotator u_rot (
            .i_clk (i_clk), .i_en (w_en),
            .i_mag ({1'b0, s_axis_tdata[34*k+17 +: MAG_W]}),
            .i_ang ({s_axis_tdata[34*k +: 16], 8'd0}),
            .o_x   (w_vx[k]), .o_y (w_vy[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < SLOTS; k++) r_act[0][k] <= s_axis_tdata[34*k+33];
            for (int s = 1; s < CSTEPS; s++) r_act[s] <= r_act[s-1];
        end
    end

    // sum of active vectors
    logic signed [VW-1:0] r_sx, r_sy;
    logic signed [VW-1:0] n_sx, n_sy;
    always_comb begin
        n_sx = '0;
        n_sy = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (r_act[CSTEPS-1][k]) begin
                n_sx = n_sx + VW'(w_vx[k]);
                n_sy = n_sy + VW'(w_vy[k]);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
    end

    // vectoring prep: spec[1] = y zero, spec[0] = x negative
    logic signed [VW-1:0] w_qx [CSTEPS+1];
    logic signed [VW-1:0] w_qy [CSTEPS+1];
    logic signed [ZW-1:0] w_qz [CSTEPS+1];
    logic [1:0]           w_sp [CSTEPS+1];
    always_comb begin
        w_sp[0] = {r_sy == 0, r_sx < 0};
        w_qx[0] = r_sx;
        w_qy[0] = r_sy;
        w_qz[0] = '0;
        if (r_sx < 0) begin
            w_qx[0] = -r_sx;
            w_qy[0] = -r_sy;
            w_qz[0] = (r_sy > 0) ? $signed(HALF_TURN) : -$signed(HALF_TURN);
        end
    end
    for (genvar g = 0; g < CSTEPS; g++) begin : g_vec
        bvfd_vec_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk), .i_en (w_en),
            .i_x (w_qx[g]), .i_y (w_qy[g]), .i_z (w_qz[g]), .i_spec (w_sp[g]),
            .o_x (w_qx[g+1]), .o_y (w_qy[g+1]), .o_z (w_qz[g+1]),
            .o_spec (w_sp[g+1])
        );
    end

    // heading rounding and clamp
    logic signed [ANG_W-1:0] r_h;
    logic signed [ANG_W-1:0] n_h;
    logic signed [ZW-1:0]    w_hr;
    always_comb begin
        w_hr = (w_qz[CSTEPS] + ZW'(128)) >>> 8;
        if (w_sp[CSTEPS][1])
            n_h = w_sp[CSTEPS][0] ? ANG_W'(32768) : '0;
        else if (w_hr > ZW'(32768))
            n_h = ANG_W'(32768);
        else if (w_hr < -ZW'(32768))
            n_h = -ANG_W'(32768);
        else
            n_h = ANG_W'(w_hr);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_h <= n_h;
    end

    // cos(h/2) rotator; heading rides alongside
    logic signed [RW-1:0]    w_c, w_cy;
    logic signed [ANG_W-1:0] r_hd [CSTEPS];
    logic [ZW-2:0]           w_hang;
    logic [ZW+6:0]           w_hx;
    assign w_hx   = (ZW+7)'($signed(r_h)) << 7;
    assign w_hang = w_hx[ZW-2:0];
    bvfd_rotator u_cos (
        .i_clk (i_clk), .i_en (w_en),
        .i_mag (17'd65536), .i_ang (w_hang),
        .o_x   (w_c), .o_y (w_cy)
    );
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hd[0] <= r_h;
            for (int s = 1; s < CSTEPS; s++) r_hd[s] <= r_hd[s-1];
        end
    end

    // speed products
    logic signed [47:0] r_lin;
    logic signed [28:0] r_trn;
    logic signed [ANG_W-1:0] r_ho;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lin <= 48'($signed({1'b0, r_spd})) * 48'(w_c) + (48'sd1 <<< 27);
            r_trn <= 29'($signed({1'b0, r_spd})) * 29'(r_hd[CSTEPS-1]) + 29'sd1024;
            r_ho  <= r_hd[CSTEPS-1];
        end
    end

    // saturated wheel speeds
    logic signed [20:0] w_lin, w_trn, w_l, w_r;
    logic [55:0]        r_out;
    function automatic logic [OUT_W-1:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767) return 16'h7fff;
        if (v < -21'sd32768) return 16'h8000;
        return v[OUT_W-1:0];
    endfunction
    assign w_lin = 21'(r_lin >>> 28);
    assign w_trn = 21'(r_trn >>> 11);
    assign w_l   = w_lin - w_trn;
    assign w_r   = w_lin + w_trn;
    always_ff @(posedge i_clk) begin
        if (w_en) r_out <= {7'd0, r_ho, sat16(w_r), sat16(w_l)};
    end
    assign m_axis_tdata = r_out;
endmodule

// ----- hw/rtl/bvfd_rot_cell.sv -----
// one rotation-mode cordic step, registered
module bvfd_rot_cell import bvfd_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [RW-1:0] i_x,
    input  logic signed [RW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [RW-1:0] o_x,
    output logic signed [RW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);
    logic signed [RW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [ZW-1:0] w_a;

    assign w_a = $signed(atan_lut(4'(STEP)));

    // step toward zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_z >= 0) begin
                r_x <= i_x - (i_y >>> STEP);
                r_y <= i_y + (i_x >>> STEP);
                r_z <= i_z - w_a;
            end else begin
                r_x <= i_x + (i_y >>> STEP);
                r_y <= i_y - (i_x >>> STEP);
                r_z <= i_z + w_a;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// ----- hw/rtl/bvfd_vec_cell.sv -----
// one vectoring-mode cordic step, registered; side data rides along
module bvfd_vec_cell import bvfd_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [VW-1:0] i_x,
    input  logic signed [VW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic [1:0]           i_spec,
    output logic signed [VW-1:0] o_x,
    output logic signed [VW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [1:0]           o_spec
);
    logic signed [VW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [1:0]           r_spec;
    logic signed [ZW-1:0] w_a;

    assign w_a = $signed(atan_lut(4'(STEP)));

    // drive y toward zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec <= i_spec;
            if (i_y > 0) begin
                r_x <= i_x + (i_y >>> STEP);
                r_y <= i_y - (i_x >>> STEP);
                r_z <= i_z + w_a;
            end else begin
                r_x <= i_x - (i_y >>> STEP);
                r_y <= i_y + (i_x >>> STEP);
                r_z <= i_z - w_a;
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_spec = r_spec;
endmodule

// ----- hw/rtl/bvfd_rotator.sv -----
// pipelined cordic rotator: mag, angle (2^23 = pi, wrapped) -> x, y
module bvfd_rotator import bvfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [MAG_W:0]       i_mag,
    input  logic [ZW-2:0]        i_ang,
    output logic signed [RW-1:0] o_x,
    output logic signed [RW-1:0] o_y
);
    logic signed [RW-1:0] w_x [CSTEPS+1];
    logic signed [RW-1:0] w_y [CSTEPS+1];
    logic signed [ZW-1:0] w_z [CSTEPS+1];
    logic signed [RW-1:0] w_x0;
    logic signed [ZW-1:0] w_a;

    // fold into [-pi/2, pi/2]
    always_comb begin
        w_a  = ZW'($signed(i_ang));
        w_x0 = $signed(RW'(i_mag) * RW'(INV_GAIN));
        w_z[0] = w_a;
        if (w_a > $signed(QUARTER_TURN)) begin
            w_x0   = -w_x0;
            w_z[0] = w_a - $signed(HALF_TURN);
        end else if (w_a < -$signed(QUARTER_TURN)) begin
            w_x0   = -w_x0;
            w_z[0] = w_a + $signed(HALF_TURN);
        end
    end
    assign w_x[0] = w_x0;
    assign w_y[0] = '0;

    for (genvar g = 0; g < CSTEPS; g++) begin : g_cell
        bvfd_rot_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),     .i_en (i_en),
            .i_x   (w_x[g]),    .i_y  (w_y[g]),    .i_z (w_z[g]),
            .o_x   (w_x[g+1]),  .o_y  (w_y[g+1]),  .o_z (w_z[g+1])
        );
    end

    assign o_x = w_x[CSTEPS];
    assign o_y = w_y[CSTEPS];
endmodule

// ----- hw/rtl/bvfd_checker.sv -----
// port-level checks
module bvfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped while stalled");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken with full output stage");
    a_rdy2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[48:32]) >= -17'sd32768 &&
                           $signed(m_axis_tdata[48:32]) <= 17'sd32768))
        else $error("heading outside range");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
        else $error("padding bits set");
endmodule

bind behavior_vector_fusion_drive bvfd_checker u_bvfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
